[hdl/ngh_pkg.sv]
// Shared types and constants for the noise gate with hold.
`default_nettype none

package ngh_pkg;

   localparam int SAMPLE_WIDTH    = 24;
   localparam int GAIN_WIDTH      = 25;
   localparam int GAIN_FRAC_BITS  = 24;
   localparam int THRESH_WIDTH    = 24;
   localparam int COEFF_WIDTH     = 24;
   localparam int HOLD_REG_WIDTH  = 20;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 25;

   localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = GAIN_WIDTH'(1) << GAIN_FRAC_BITS;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTACK    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOOR     = 3'd4;

   // register reset values
   localparam logic [THRESH_WIDTH-1:0]   THRESHOLD_RST = 24'd84;
   localparam logic [COEFF_WIDTH-1:0]    ATTACK_RST    = 24'd16398454;
   localparam logic [COEFF_WIDTH-1:0]    RELEASE_RST   = 24'd16773412;
   localparam logic [HOLD_REG_WIDTH-1:0] HOLD_RST      = 20'd2205;
   localparam logic [GAIN_WIDTH-1:0]     FLOOR_RST     = 25'd2;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
      logic                           block_start;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic [GAIN_WIDTH-1:0]          gain_now;
      logic                           gate_open;
   } rsp_type;

   // register contents as seen by the datapath
   typedef struct packed {
      logic [THRESH_WIDTH-1:0]   threshold_level;
      logic [COEFF_WIDTH-1:0]    attack_coeff;
      logic [COEFF_WIDTH-1:0]    release_coeff;
      logic [HOLD_REG_WIDTH-1:0] hold_samples;
      logic [GAIN_WIDTH-1:0]     floor_gain;   // range floor saturated to unity
   } cfg_type;

endpackage

`default_nettype wire

[hdl/ngh_csr.sv]
// Configuration register file of the noise gate with hold.
`default_nettype none

module ngh_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [ngh_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ngh_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output ngh_pkg::cfg_type                         cfg
);
   import ngh_pkg::*;

   logic [THRESH_WIDTH-1:0]   threshold_ff, threshold_in;
   logic [COEFF_WIDTH-1:0]    attack_ff, attack_in;
   logic [COEFF_WIDTH-1:0]    release_ff, release_in;
   logic [HOLD_REG_WIDTH-1:0] hold_ff, hold_in;
   logic [GAIN_WIDTH-1:0]     floor_ff, floor_in;

   always_comb begin
      threshold_in = threshold_ff;
      attack_in    = attack_ff;
      release_in   = release_ff;
      hold_in      = hold_ff;
      floor_in     = floor_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_wdata[THRESH_WIDTH-1:0];
            CSR_ATTACK:    attack_in    = csr_wdata[COEFF_WIDTH-1:0];
            CSR_RELEASE:   release_in   = csr_wdata[COEFF_WIDTH-1:0];
            CSR_HOLD:      hold_in      = csr_wdata[HOLD_REG_WIDTH-1:0];
            CSR_FLOOR:     floor_in     = csr_wdata[GAIN_WIDTH-1:0];
            default:       ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
         attack_ff    <= ATTACK_RST;
         release_ff   <= RELEASE_RST;
         hold_ff      <= HOLD_RST;
         floor_ff     <= FLOOR_RST;
      end else begin
         threshold_ff <= threshold_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         hold_ff      <= hold_in;
         floor_ff     <= floor_in;
      end
   end

   always_comb begin
      cfg.threshold_level = threshold_ff;
      cfg.attack_coeff    = attack_ff;
      cfg.release_coeff   = release_ff;
      cfg.hold_samples    = hold_ff;
      cfg.floor_gain      = (floor_ff > GAIN_UNITY) ? GAIN_UNITY : floor_ff;
   end

endmodule

`default_nettype wire

[hdl/noise_gate_with_hold_core.sv]
// Top level of the noise gate with hold: sequencer, shared multiplier, gain state.
// A taken req_ beat passes through ST_STEP, ST_GAIN and ST_SCALE; its result is registered
// on rsp_ as ST_SCALE is left, and ST_SCALE waits while the output register is blocked. One
// shared 25x25 multiplier is used twice per sample (smoothing step, then sample scaling)
// under a 4-state sequencer. A new sample is taken in the cycle the previous result is written out.
// Reset (synchronous): gain to unity, hold counter to zero, registers to defaults.
`default_nettype none

module noise_gate_with_hold_core #(
   parameter int COEFF_FRAC_BITS = 24,
   parameter int HOLD_WIDTH      = 20
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ngh_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ngh_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [ngh_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ngh_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import ngh_pkg::*;

   localparam int PROD_WIDTH = 2 * GAIN_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;

   // one-hot sequencer
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,   // waiting for a sample
      ST_STEP  = 4'b0010,   // multiplier: |gain - target| * coeff
      ST_GAIN  = 4'b0100,   // apply step, clamp, update gain
      ST_SCALE = 4'b1000    // multiplier: |sample| * gain, then write out
   } state_type;

   cfg_type cfg;

   ngh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   state_type                 state_ff, state_in;
   logic [GAIN_WIDTH-1:0]     gain_ff, gain_in;
   logic [HOLD_WIDTH-1:0]     hold_ff, hold_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // per-sample working registers (payload, no reset)
   logic [SAMPLE_WIDTH-1:0]   mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic                      open_ff, open_in;
   logic                      rise_ff, rise_in;
   logic [GAIN_WIDTH-1:0]     target_ff, target_in;
   logic [GAIN_WIDTH-1:0]     diff_ff, diff_in;
   logic [PROD_WIDTH-1:0]     prod_ff, prod_in;

   logic                      out_free;
   logic                      req_take;
   logic                      finishing;

   // ---------------------------------------------------------------
   // Handshake. The output register frees the sequencer from rsp_stall
   // except when a finished result has nowhere to go.
   // ---------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finishing = (state_ff == ST_SCALE) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || finishing);
   assign req_take  = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Sample intake: magnitude, gate decision, hold counter, target and
   // the smoothing direction. Both candidate targets (unity and floor)
   // are compared against the kept gain in parallel with the threshold test.
   // ---------------------------------------------------------------
   logic [SAMPLE_WIDTH-1:0]   raw;
   logic [SAMPLE_WIDTH-1:0]   mag;
   logic                      above;
   logic [HOLD_WIDTH-1:0]     hold_base;
   logic                      rise_unity;
   logic [GAIN_WIDTH-1:0]     diff_unity;
   logic                      rise_floor;
   logic [GAIN_WIDTH-1:0]     diff_floor;

   always_comb begin
      raw   = req_data.sample_in;
      // most negative sample maps to 2^(SAMPLE_WIDTH-1), still fits unsigned
      mag   = raw[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH'(0) - raw) : raw;
      above = mag >= cfg.threshold_level;
      hold_base = req_data.block_start ? HOLD_WIDTH'(0) : hold_ff;

      rise_unity = gain_ff != GAIN_UNITY;
      diff_unity = GAIN_UNITY - gain_ff;
      rise_floor = gain_ff < cfg.floor_gain;
      diff_floor = rise_floor ? (cfg.floor_gain - gain_ff) : (gain_ff - cfg.floor_gain);
   end

   // ---------------------------------------------------------------
   // Shared multiplier: operands chosen by the sequencer state.
   // ---------------------------------------------------------------
   logic [GAIN_WIDTH-1:0] mul_a;
   logic [GAIN_WIDTH-1:0] mul_b;
   logic [PROD_WIDTH-1:0] mul_p;

   always_comb begin
      if (state_ff == ST_STEP) begin
         mul_a = diff_ff;
         mul_b = GAIN_WIDTH'(rise_ff ? cfg.attack_coeff : cfg.release_coeff);
      end else begin
         mul_a = GAIN_WIDTH'(mag_ff);
         mul_b = gain_ff;
      end
      mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   end

   // ---------------------------------------------------------------
   // Gain update: step truncated toward the target, then clamp to
   // [floor, unity].
   // ---------------------------------------------------------------
   logic [PROD_WIDTH-1:0]       step;
   logic signed [SUM_WIDTH-1:0] tgt_s;
   logic signed [SUM_WIDTH-1:0] step_s;
   logic signed [SUM_WIDTH-1:0] sum_s;
   logic signed [SUM_WIDTH-1:0] unity_s;
   logic signed [SUM_WIDTH-1:0] floor_s;
   logic [GAIN_WIDTH-1:0]       gain_clamped;

   always_comb begin
      step    = prod_ff >> COEFF_FRAC_BITS;
      tgt_s   = $signed(SUM_WIDTH'(target_ff));
      step_s  = $signed(SUM_WIDTH'(step));
      unity_s = $signed(SUM_WIDTH'(GAIN_UNITY));
      floor_s = $signed(SUM_WIDTH'(cfg.floor_gain));
      sum_s   = rise_ff ? (tgt_s - step_s) : (tgt_s + step_s);
      if (sum_s > unity_s) begin
         gain_clamped = GAIN_UNITY;
      end else if (sum_s < floor_s) begin
         gain_clamped = cfg.floor_gain;
      end else begin
         gain_clamped = sum_s[GAIN_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Output scaling: product >> 24 truncates the magnitude, sign restored
   // afterwards, so the result rounds toward zero. Taken straight off the
   // multiplier while in ST_SCALE.
   // ---------------------------------------------------------------
   logic [SAMPLE_WIDTH-1:0] scaled;
   logic [SAMPLE_WIDTH-1:0] signed_out;

   always_comb begin
      scaled     = mul_p[GAIN_FRAC_BITS +: SAMPLE_WIDTH];
      signed_out = neg_ff ? (SAMPLE_WIDTH'(0) - scaled) : scaled;
   end

   // ---------------------------------------------------------------
   // Sequencer and next-state values
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      open_in      = open_ff;
      rise_in      = rise_ff;
      target_in    = target_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;

      case (state_ff)
         ST_IDLE: begin
         end
         ST_STEP: begin
            prod_in  = mul_p;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in  = gain_clamped;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.sample_out = $signed(signed_out);
               rsp_data_in.gain_now   = gain_ff;
               rsp_data_in.gate_open  = open_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a blocked result keeps mag_ff and gain_ff, so the scaled value
      // stays the same each cycle it waits
      if (req_take) begin
         mag_in = mag;
         neg_in = raw[SAMPLE_WIDTH-1];
         if (above) begin
            open_in   = 1'b1;
            hold_in   = HOLD_WIDTH'(cfg.hold_samples);
            target_in = GAIN_UNITY;
            rise_in   = rise_unity;
            diff_in   = diff_unity;
         end else if (hold_base != HOLD_WIDTH'(0)) begin
            open_in   = 1'b1;
            hold_in   = hold_base - HOLD_WIDTH'(1);
            target_in = GAIN_UNITY;
            rise_in   = rise_unity;
            diff_in   = diff_unity;
         end else begin
            open_in   = 1'b0;
            hold_in   = hold_base;
            target_in = cfg.floor_gain;
            rise_in   = rise_floor;
            diff_in   = diff_floor;
         end
         state_in = ST_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_UNITY;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      open_ff     <= open_in;
      rise_ff     <= rise_in;
      target_ff   <= target_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for noise_gate_with_hold_core: directed and random samples.
`timescale 1ns / 1ps

module tb;
   import ngh_pkg::*;

   // Timeout, in clock cycles. It covers roughly 1900 beats in the worst idling phase,
   // plus the long hold-off, many times over.
   localparam int CYCLE_LIMIT = 400000;
   localparam int COEFF_FRAC  = 24;       // dut default COEFF_FRAC_BITS
   localparam int MAX_REPORTS = 40;       // mismatch lines printed before going quiet
   localparam int PHASE_ITEMS = 450;
   localparam int SETTING_RUN = 150;      // samples between register changes
   localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = CSR_FLOOR + 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = '1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   noise_gate_with_hold_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Register shadow and gain state of the predictor
   // ---------------------------------------------------------------------------
   logic [THRESH_WIDTH-1:0]   thresh_reg   = THRESHOLD_RST;
   logic [COEFF_WIDTH-1:0]    attack_reg   = ATTACK_RST;
   logic [COEFF_WIDTH-1:0]    release_reg  = RELEASE_RST;
   logic [HOLD_REG_WIDTH-1:0] hold_reg     = HOLD_RST;
   logic [GAIN_WIDTH-1:0]     floor_reg    = FLOOR_RST;   // raw, may exceed unity
   logic [GAIN_WIDTH-1:0]     gain_state   = GAIN_UNITY;
   logic [HOLD_REG_WIDTH-1:0] hold_count   = '0;

   rsp_type pending_outputs[$];   // gated samples still owed by the dut
   rsp_type want_rsp;

   int error_count   = 0;
   int samples_sent  = 0;
   int settings_used = 1;
   int open_seen     = 0;
   int closed_seen   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;         // chance per cycle that the sender sits idle
   int stall_pct     = 0;         // chance per cycle that the receiver stalls
   int holdoff_left  = 0;         // long receiver hold-off, counted down below

   // One sample through the gate: hold logic, smoothing, clamp, then scaling.
   function automatic rsp_type predict_gated_sample(input req_type item);
      rsp_type           res;
      logic [SAMPLE_WIDTH-1:0] raw;
      logic              neg;
      logic              gate_is_open;
      longint unsigned   mag, floor_g, target, step, prod;
      longint            g;
      raw = item.sample_in;
      neg = raw[SAMPLE_WIDTH-1];
      // most negative sample keeps its full magnitude of 2^(width-1)
      mag = neg ? ((64'd1 << SAMPLE_WIDTH) - raw) : raw;
      floor_g = (floor_reg > GAIN_UNITY) ? GAIN_UNITY : floor_reg;
      if (item.block_start)
         hold_count = '0;
      if (mag >= thresh_reg) begin
         gate_is_open = 1'b1;
         hold_count   = hold_reg;
         target       = GAIN_UNITY;
      end else if (hold_count != 0) begin
         gate_is_open = 1'b1;
         hold_count   = hold_count - 1'b1;
         target       = GAIN_UNITY;
      end else begin
         gate_is_open = 1'b0;
         target       = floor_g;
      end
      // step truncates toward the target
      if (gain_state < target) begin
         step = ((target - gain_state) * attack_reg) >> COEFF_FRAC;
         g    = longint'(target) - longint'(step);
      end else begin
         step = ((gain_state - target) * release_reg) >> COEFF_FRAC;
         g    = longint'(target) + longint'(step);
      end
      if (g > longint'(GAIN_UNITY))
         g = longint'(GAIN_UNITY);
      if (g < longint'(floor_g))
         g = longint'(floor_g);
      gain_state = g[GAIN_WIDTH-1:0];
      prod = (mag * gain_state) >> GAIN_FRAC_BITS;
      if (neg)
         prod = (64'd1 << SAMPLE_WIDTH) - prod;
      res.sample_out = prod[SAMPLE_WIDTH-1:0];
      res.gain_now   = gain_state;
      res.gate_open  = gate_is_open;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, or a long hold-off while holdoff_left is nonzero
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      if (error_count == MAX_REPORTS)
         $display("%0t: further mismatch reports suppressed", $time);
   endtask

   // Result checker: every accepted rsp_ beat is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            report_field("unexpected beat, sample_out", '0, rsp_data.sample_out);
         end else begin
            want_rsp = pending_outputs.pop_front();
            if (rsp_data.sample_out !== want_rsp.sample_out)
               report_field("sample_out", want_rsp.sample_out, rsp_data.sample_out);
            if (rsp_data.gain_now !== want_rsp.gain_now)
               report_field("gain_now", want_rsp.gain_now, rsp_data.gain_now);
            if (rsp_data.gate_open !== want_rsp.gate_open)
               report_field("gate_open", want_rsp.gate_open, rsp_data.gate_open);
            if (want_rsp.gate_open)
               open_seen++;
            else
               closed_seen++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still owed", $time, pending_outputs.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Shared driving tasks
   // ---------------------------------------------------------------------------
   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic start);
      req_type item;
      item.sample_in   = value;
      item.block_start = start;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pending_outputs.push_back(predict_gated_sample(item));
      samples_sent++;
   endtask

   // Drop valid and wait until every owed result has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
   endtask

   // One register write; csr_we then drops low, so it never toggles twice in a step.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_THRESHOLD: thresh_reg  = value[THRESH_WIDTH-1:0];
         CSR_ATTACK:    attack_reg  = value[COEFF_WIDTH-1:0];
         CSR_RELEASE:   release_reg = value[COEFF_WIDTH-1:0];
         CSR_HOLD:      hold_reg    = value[HOLD_REG_WIDTH-1:0];
         CSR_FLOOR:     floor_reg   = value[GAIN_WIDTH-1:0];
         default: ;     // unused indexes are ignored by the block
      endcase
      @(posedge clock);
   endtask

   function automatic logic [SAMPLE_WIDTH-1:0] signed_of(input logic [31:0] mag);
      logic [SAMPLE_WIDTH-1:0] s;
      s = mag[SAMPLE_WIDTH-1:0];        // 2^23 wraps to the most negative value
      return $urandom_range(1) ? -s : s;
   endfunction

   // Sample at or above the threshold (any sample if no magnitude can reach it).
   function automatic logic [SAMPLE_WIDTH-1:0] loud_sample();
      if (thresh_reg > (1 << (SAMPLE_WIDTH-1)))
         return SAMPLE_WIDTH'($urandom);
      return signed_of($urandom_range(1 << (SAMPLE_WIDTH-1), thresh_reg));
   endfunction

   // Sample below the threshold (falls back to loud when the threshold is zero).
   function automatic logic [SAMPLE_WIDTH-1:0] quiet_sample();
      logic [31:0] top;
      if (thresh_reg == 0)
         return loud_sample();
      top = thresh_reg - 1;
      if (top > (1 << (SAMPLE_WIDTH-1)))
         top = 1 << (SAMPLE_WIDTH-1);
      return signed_of($urandom_range(top, 0));
   endfunction

   task automatic randomize_settings();
      int pick;
      logic [CSR_DATA_WIDTH-1:0] v;
      pick = $urandom_range(9);
      v = (pick == 0) ? '0 : (pick == 1) ? (1 << (SAMPLE_WIDTH-1)) :
          (pick < 5) ? $urandom_range(4096) : $urandom_range(1 << (SAMPLE_WIDTH-1));
      write_reg(CSR_THRESHOLD, v);
      pick = $urandom_range(9);
      v = (pick < 2) ? '0 : (pick < 4) ? 25'hFFFFFF :
          (pick < 7) ? $urandom_range(24'hFFFFFF, 24'hF00000) : $urandom & 24'hFFFFFF;
      write_reg(CSR_ATTACK, v);
      pick = $urandom_range(9);
      v = (pick < 2) ? '0 : (pick < 4) ? 25'hFFFFFF :
          (pick < 7) ? $urandom_range(24'hFFFFFF, 24'hF00000) : $urandom & 24'hFFFFFF;
      write_reg(CSR_RELEASE, v);
      pick = $urandom_range(9);
      v = (pick < 7) ? $urandom_range(16) : (pick < 9) ? $urandom_range(200) :
          $urandom & 20'hFFFFF;
      write_reg(CSR_HOLD, v);
      pick = $urandom_range(19);
      v = (pick < 2) ? '0 : (pick < 4) ? GAIN_UNITY :
          (pick == 4) ? ($urandom | GAIN_UNITY) : $urandom_range(GAIN_UNITY);
      write_reg(CSR_FLOOR, v);
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset registers: threshold edges, full-scale samples, block start dropping hold.
   task automatic test_defaults();
      send_sample(24'd0, 1'b0);          // quiet, hold empty: gate closed, release
      send_sample(24'd83, 1'b0);         // one below threshold
      send_sample(-24'sd83, 1'b0);
      send_sample(24'd84, 1'b0);         // exactly at threshold opens, hold loaded
      send_sample(-24'sd84, 1'b0);
      send_sample(24'h7FFFFF, 1'b0);     // largest positive
      send_sample(MOST_NEG, 1'b0);       // most negative, gain still just under unity
      send_sample(-24'sd1, 1'b1);        // block start clears hold: closes at once
      send_sample(24'd1, 1'b0);
      wait_idle();
   endtask

   // Register extremes, floor above unity, unused register indexes.
   task automatic test_register_extremes();
      write_reg(CSR_THRESHOLD, '0);      // zero threshold: even silence opens
      send_sample(24'd0, 1'b0);
      wait_idle();
      write_reg(CSR_THRESHOLD, 1 << (SAMPLE_WIDTH-1));
      write_reg(CSR_HOLD, '0);           // zero hold reload; a count already loaded keeps running
      write_reg(CSR_RELEASE, '0);        // instant release
      write_reg(CSR_FLOOR, '0);
      send_sample(-24'sd8388607, 1'b0);  // just under, but still held open by the remaining hold count
      send_sample(MOST_NEG, 1'b0);       // only the most negative sample reaches it
      wait_idle();
      write_reg(CSR_ATTACK, 25'hFFFFFF);
      write_reg(CSR_RELEASE, 25'hFFFFFF);
      write_reg(CSR_FLOOR, '1);          // floor above unity saturates, gain pinned
      send_sample(24'd5, 1'b0);
      wait_idle();
      write_reg(CSR_THRESHOLD, '1);      // upper bit dropped, no magnitude can reach
      write_reg(CSR_FLOOR, GAIN_UNITY);
      send_sample(MOST_NEG, 1'b0);
      wait_idle();
      write_reg(CSR_THRESHOLD, 25'd100);
      write_reg(CSR_HOLD, 25'hFFFFF);    // longest hold
      write_reg(CSR_FLOOR, '0);
      send_sample(24'd100, 1'b0);
      send_sample(24'd3, 1'b0);          // held open, counter runs down
      send_sample(24'd3, 1'b1);          // block start ends the hold
      wait_idle();
      write_reg(CSR_SPARE_LO, '1);       // unused indexes must change nothing
      write_reg(CSR_SPARE_HI, '1);
      send_sample(-24'sd3, 1'b0);
      wait_idle();
      write_reg(CSR_THRESHOLD, 25'd50);
      write_reg(CSR_HOLD, 25'd1);
      write_reg(CSR_ATTACK, '0);
      send_sample(24'd60, 1'b0);
      send_sample(24'd1, 1'b0);          // last held sample
      send_sample(-24'sd1, 1'b0);        // now closed
      wait_idle();
      settings_used += 6;
   endtask

   // Burst and silence runs so the gate keeps opening, holding and closing.
   task automatic run_gate_traffic(input int count);
      logic loud_run;
      int   run_left;
      int   quiet_max;
      logic [SAMPLE_WIDTH-1:0] s;
      loud_run = 1'b0;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            loud_run  = !loud_run;
            quiet_max = (hold_reg > 40) ? 48 : hold_reg + 8;
            run_left  = loud_run ? $urandom_range(6, 1) : $urandom_range(quiet_max, 1);
         end
         run_left--;
         case ($urandom_range(19))
            0:       s = SAMPLE_WIDTH'($urandom);
            1:       s = $urandom_range(1) ? MOST_NEG : 24'h7FFFFF;
            default: s = loud_run ? loud_sample() : quiet_sample();
         endcase
         send_sample(s, $urandom_range(24) == 0);
      end
   endtask

   // Receiver holds off for a long stretch while samples keep coming, then the
   // sender pauses until everything owed has drained.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      randomize_settings();
      holdoff_left = 300;
      run_gate_traffic(40);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_chance);
      send_idle_pct = idle_pct;
      stall_pct     = stall_chance;
      for (int done = 0; done < PHASE_ITEMS; done += SETTING_RUN) begin
         wait_idle();
         randomize_settings();
         run_gate_traffic(SETTING_RUN);
      end
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_register_extremes();
      test_backpressure();
      test_random_traffic(0, 0);
      test_random_traffic(82, 0);
      test_random_traffic(0, 82);
      test_random_traffic(17, 17);
      wait_idle();
      repeat (8) @(posedge clock);    // catch any stray beat after the last one
      $display("covered %0d samples across %0d register settings", samples_sent,
               settings_used);
      $display("gate open on %0d results, closed on %0d", open_seen, closed_seen);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[files.f]
hdl/ngh_pkg.sv
hdl/ngh_csr.sv
hdl/noise_gate_with_hold_core.sv
sim/tb.sv
